// ===== rtl/pnn_pkg.sv =====
`default_nettype none
package pnn_pkg;

	localparam int CRD_W  = 24;
	localparam int SUM_W  = 64;
	localparam int NRM_W  = 16;
	localparam int THR_W  = 32;
	localparam int MUL_W  = 33;
	localparam int PRD_W  = 66;
	localparam int ACC_W  = 130;
	localparam int NUM_W  = 47;
	localparam int QUO_W  = 15;
	localparam int QDEPTH = 2;

	localparam logic [THR_W-1:0] THR_RESET = 32'd1678;

	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		crd_t z;
		crd_t y;
		crd_t x;
	} xyz_t;

	typedef struct packed {
		sum_t sx;
		sum_t sy;
		sum_t sz;
		xyz_t v0;
		xyz_t v1;
		xyz_t v2;
		logic few;
		logic many;
	} facet_t;

endpackage
`default_nettype wire

// ===== rtl/pnn_front.sv =====
`default_nettype none
module pnn_front import pnn_pkg::*; #(
	parameter int MAX_VERTS = 256,
	localparam int CNT_W = $clog2(MAX_VERTS + 2)
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire xyz_t   in_pos,
	input  wire logic   in_last,
	output logic        push_valid,
	input  wire logic   push_ready,
	output facet_t      push_data
);

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_EDGE  = 2'd1;
	localparam logic [1:0] F_CLOSE = 2'd2;
	localparam logic [1:0] F_PUSH  = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTS);

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	xyz_t             first_q, second_q, third_q, prev_q, op_a_q, op_b_q;
	logic             edge_en_q, last_q;
	sum_t             sx_q, sy_q, sz_q;
	xyz_t             ea, eb;
	logic             add_en;
	sum_t             tx, ty, tz;
	logic             keep;

	function automatic sum_t term(input crd_t a1, b1, a2, b2);
		logic signed [CRD_W:0]     d, s;
		logic signed [2*CRD_W+1:0] p;
		d = $signed({a1[CRD_W-1], a1}) - $signed({b1[CRD_W-1], b1});
		s = $signed({a2[CRD_W-1], a2}) + $signed({b2[CRD_W-1], b2});
		p = d * s;
		return $signed({{(SUM_W-2*CRD_W-2){p[2*CRD_W+1]}}, p});
	endfunction

	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign keep       = cnt_q < CNT_MAX;

	assign ea     = (state_q == F_CLOSE) ? prev_q  : op_a_q;
	assign eb     = (state_q == F_CLOSE) ? first_q : op_b_q;
	assign add_en = (state_q == F_CLOSE) || edge_en_q;
	assign tx     = term(ea.y, eb.y, ea.z, eb.z);
	assign ty     = term(ea.z, eb.z, ea.x, eb.x);
	assign tz     = term(ea.x, eb.x, ea.y, eb.y);

	always_comb begin
		push_data.sx   = sx_q;
		push_data.sy   = sy_q;
		push_data.sz   = sz_q;
		push_data.v0   = first_q;
		push_data.v1   = second_q;
		push_data.v2   = third_q;
		push_data.few  = cnt_q < CNT_W'(3);
		push_data.many = cnt_q > CNT_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			cnt_q     <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			sz_q      <= '0;
			edge_en_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						edge_en_q <= keep && (cnt_q != '0);
						last_q    <= in_last;
						if (cnt_q <= CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
						state_q   <= F_EDGE;
					end
				end
				F_EDGE, F_CLOSE: begin
					if (add_en) begin
						sx_q <= sx_q + tx;
						sy_q <= sy_q + ty;
						sz_q <= sz_q + tz;
					end
					if (state_q == F_CLOSE) state_q <= F_PUSH;
					else state_q <= last_q ? F_CLOSE : F_IDLE;
				end
				F_PUSH: begin
					if (push_ready) begin
						cnt_q   <= '0;
						sx_q    <= '0;
						sy_q    <= '0;
						sz_q    <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid && keep) begin
			op_a_q <= prev_q;
			op_b_q <= in_pos;
			prev_q <= in_pos;
			if (cnt_q == CNT_W'(0)) first_q  <= in_pos;
			if (cnt_q == CNT_W'(1)) second_q <= in_pos;
			if (cnt_q == CNT_W'(2)) third_q  <= in_pos;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pnn_queue.sv =====
`default_nettype none
module pnn_queue import pnn_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire facet_t push_data,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output facet_t      pop_data
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	facet_t           mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign push_ready = cnt_q < CNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= adv(wr_q);
			if (do_pop) rd_q <= adv(rd_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== rtl/pnn_back.sv =====
`default_nettype none
module pnn_back import pnn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [THR_W-1:0] thr,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	input  wire facet_t           pop_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [NRM_W-1:0]      out_nx,
	output logic [NRM_W-1:0]      out_ny,
	output logic [NRM_W-1:0]      out_nz,
	output logic                  out_fb,
	output logic                  out_dg,
	output logic                  out_many
);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_SQ    = 4'd1;
	localparam logic [3:0] B_CMP   = 4'd2;
	localparam logic [3:0] B_CROSS = 4'd3;
	localparam logic [3:0] B_CSET  = 4'd4;
	localparam logic [3:0] B_SHIFT = 4'd5;
	localparam logic [3:0] B_QSUM  = 4'd6;
	localparam logic [3:0] B_SQRT  = 4'd7;
	localparam logic [3:0] B_DLOAD = 4'd8;
	localparam logic [3:0] B_DIV   = 4'd9;
	localparam logic [3:0] B_OUT   = 4'd10;

	logic [3:0]             state_q;
	logic [3:0]             cnt_q, k;
	facet_t                 rec_q;
	logic [SUM_W-1:0]       mag0_q, mag1_q, mag2_q;
	logic                   neg0_q, neg1_q, neg2_q;
	logic [SUM_W-1:0]       m0_q, m1_q, m2_q;
	logic                   sg0_q, sg1_q, sg2_q;
	sum_t                   c0_q, c1_q, c2_q;
	logic [ACC_W-1:0]       acc_q, addend;
	logic [SUM_W-1:0]       tsq_q;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [PRD_W-1:0] prod_s1;
	logic [SUM_W-1:0]       v_q, r_q, bit_q, rb, mx, mc, mq;
	logic [THR_W-1:0]       len_q;
	logic [NUM_W-1:0]       rem_q, trial;
	logic [QUO_W-1:0]       quo_q, quo_n;
	logic [3:0]             qb_q;
	logic [1:0]             ci_q;
	logic                   fb_q, dg_q;
	logic [NRM_W-1:0]       n0_q, n1_q, n2_q, nv;
	logic signed [CRD_W:0]  e1x, e1y, e1z, e2x, e2y, e2z;
	logic [SUM_W-1:0]       msq;

	function automatic logic [SUM_W-1:0] absv(input logic [SUM_W-1:0] v);
		return v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
	endfunction

	function automatic logic [SUM_W-1:0] pick3(input logic [SUM_W-1:0] a, b, c,
			input logic [1:0] i);
		logic [SUM_W-1:0] r;
		unique case (i)
			2'd0: r = a;
			2'd1: r = b;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic signed [MUL_W-1:0] sx25(input logic signed [CRD_W:0] e);
		return $signed({{(MUL_W-CRD_W-1){e[CRD_W]}}, e});
	endfunction

	function automatic logic signed [CRD_W:0] dif(input crd_t a, b);
		return $signed({a[CRD_W-1], a}) - $signed({b[CRD_W-1], b});
	endfunction

	assign e1x = dif(rec_q.v1.x, rec_q.v0.x);
	assign e1y = dif(rec_q.v1.y, rec_q.v0.y);
	assign e1z = dif(rec_q.v1.z, rec_q.v0.z);
	assign e2x = dif(rec_q.v2.x, rec_q.v0.x);
	assign e2y = dif(rec_q.v2.y, rec_q.v0.y);
	assign e2z = dif(rec_q.v2.z, rec_q.v0.z);

	assign pop_ready = (state_q == B_IDLE);
	assign k         = cnt_q - 4'd1;
	assign rb        = r_q + bit_q;
	assign mc        = pick3(m0_q, m1_q, m2_q, ci_q);
	assign mq        = pick3(m0_q, m1_q, m2_q, cnt_q[1:0]);
	assign trial     = NUM_W'(len_q) << qb_q;

	always_comb begin
		mx = m0_q;
		if (m1_q > mx) mx = m1_q;
		if (m2_q > mx) mx = m2_q;
	end

	always_comb begin
		msq = pick3(mag0_q, mag1_q, mag2_q, cnt_q[3:2]);
		ma  = '0;
		mb  = '0;
		unique case (state_q)
			B_SQ: begin
				if (cnt_q < 4'd12) begin
					ma = $signed({1'b0, cnt_q[1] ? msq[63:32] : msq[31:0]});
					mb = $signed({1'b0, cnt_q[0] ? msq[63:32] : msq[31:0]});
				end else begin
					ma = $signed({1'b0, thr});
					mb = $signed({1'b0, thr});
				end
			end
			B_CROSS: begin
				unique case (cnt_q)
					4'd0: begin ma = sx25(e1y); mb = sx25(e2z); end
					4'd1: begin ma = sx25(e1z); mb = sx25(e2y); end
					4'd2: begin ma = sx25(e1z); mb = sx25(e2x); end
					4'd3: begin ma = sx25(e1x); mb = sx25(e2z); end
					4'd4: begin ma = sx25(e1x); mb = sx25(e2y); end
					default: begin ma = sx25(e1y); mb = sx25(e2x); end
				endcase
			end
			B_QSUM: begin
				ma = $signed({2'b0, mq[30:0]});
				mb = ma;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		unique case (k[1:0])
			2'd0:    addend = ACC_W'(prod_s1[SUM_W-1:0]);
			2'd3:    addend = ACC_W'(prod_s1[SUM_W-1:0]) << 64;
			default: addend = ACC_W'(prod_s1[SUM_W-1:0]) << 32;
		endcase
	end

	always_comb begin
		quo_n = quo_q;
		if (rem_q >= trial) quo_n[qb_q] = 1'b1;
		unique case (ci_q)
			2'd0:    nv = sg0_q ? -{1'b0, quo_n} : {1'b0, quo_n};
			2'd1:    nv = sg1_q ? -{1'b0, quo_n} : {1'b0, quo_n};
			default: nv = sg2_q ? -{1'b0, quo_n} : {1'b0, quo_n};
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) state_q <= pop_data.few ? B_OUT : B_SQ;
				end
				B_SQ:    if (cnt_q == 4'd13) state_q <= B_CMP;
				B_CMP:   state_q <= (acc_q > ACC_W'(tsq_q)) ? B_SHIFT : B_CROSS;
				B_CROSS: if (cnt_q == 4'd6) state_q <= B_CSET;
				B_CSET:  state_q <= B_SHIFT;
				B_SHIFT: begin
					if (mx == '0) state_q <= B_OUT;
					else if (mx[63:31] == '0 && mx[30]) state_q <= B_QSUM;
				end
				B_QSUM:  if (cnt_q == 4'd3) state_q <= B_SQRT;
				B_SQRT:  if (bit_q == '0) state_q <= B_DLOAD;
				B_DLOAD: state_q <= B_DIV;
				B_DIV: begin
					if (qb_q == 4'd0) state_q <= (ci_q == 2'd2) ? B_OUT : B_DLOAD;
				end
				B_OUT:   if (!out_valid || out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				rec_q  <= pop_data;
				mag0_q <= absv(pop_data.sx);
				mag1_q <= absv(pop_data.sy);
				mag2_q <= absv(pop_data.sz);
				neg0_q <= pop_data.sx[SUM_W-1];
				neg1_q <= pop_data.sy[SUM_W-1];
				neg2_q <= pop_data.sz[SUM_W-1];
				fb_q   <= 1'b0;
				dg_q   <= pop_data.few;
				cnt_q  <= '0;
				acc_q  <= '0;
			end
			B_SQ: begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q != 4'd0) begin
					if (k < 4'd12) acc_q <= acc_q + addend;
					else tsq_q <= prod_s1[SUM_W-1:0];
				end
			end
			B_CMP: begin
				m0_q  <= mag0_q;
				m1_q  <= mag1_q;
				m2_q  <= mag2_q;
				sg0_q <= neg0_q;
				sg1_q <= neg1_q;
				sg2_q <= neg2_q;
				fb_q  <= !(acc_q > ACC_W'(tsq_q));
				c0_q  <= '0;
				c1_q  <= '0;
				c2_q  <= '0;
				cnt_q <= '0;
			end
			B_CROSS: begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q != 4'd0) begin
					unique case (k[2:1])
						2'd0: c0_q <= k[0] ? c0_q - prod_s1[SUM_W-1:0]
							: c0_q + prod_s1[SUM_W-1:0];
						2'd1: c1_q <= k[0] ? c1_q - prod_s1[SUM_W-1:0]
							: c1_q + prod_s1[SUM_W-1:0];
						default: c2_q <= k[0] ? c2_q - prod_s1[SUM_W-1:0]
							: c2_q + prod_s1[SUM_W-1:0];
					endcase
				end
			end
			B_CSET: begin
				m0_q  <= absv(c0_q);
				m1_q  <= absv(c1_q);
				m2_q  <= absv(c2_q);
				sg0_q <= c0_q[SUM_W-1];
				sg1_q <= c1_q[SUM_W-1];
				sg2_q <= c2_q[SUM_W-1];
			end
			B_SHIFT: begin
				cnt_q <= '0;
				v_q   <= '0;
				if (mx == '0) begin
					dg_q <= 1'b1;
				end else if (mx[63:31] != '0) begin
					m0_q <= m0_q >> 1;
					m1_q <= m1_q >> 1;
					m2_q <= m2_q >> 1;
				end else if (!mx[30]) begin
					m0_q <= m0_q << 1;
					m1_q <= m1_q << 1;
					m2_q <= m2_q << 1;
				end
			end
			B_QSUM: begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q != 4'd0) v_q <= v_q + prod_s1[SUM_W-1:0];
				r_q   <= '0;
				bit_q <= SUM_W'(1) << 62;
			end
			B_SQRT: begin
				if (bit_q == '0) begin
					len_q <= r_q[THR_W-1:0];
					ci_q  <= 2'd0;
				end else begin
					if (v_q >= rb) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			B_DLOAD: begin
				rem_q <= NUM_W'({mc[30:0], 14'b0}) + NUM_W'(len_q[THR_W-1:1]);
				quo_q <= '0;
				qb_q  <= 4'(QUO_W - 1);
			end
			B_DIV: begin
				if (rem_q >= trial) rem_q <= rem_q - trial;
				quo_q <= quo_n;
				if (qb_q == 4'd0) begin
					unique case (ci_q)
						2'd0:    n0_q <= nv;
						2'd1:    n1_q <= nv;
						default: n2_q <= nv;
					endcase
					ci_q <= ci_q + 2'd1;
				end else begin
					qb_q <= qb_q - 4'd1;
				end
			end
			B_OUT: begin
				if (!out_valid || out_ready) begin
					out_nx   <= dg_q ? '0 : n0_q;
					out_ny   <= dg_q ? '0 : n1_q;
					out_nz   <= dg_q ? '0 : n2_q;
					out_fb   <= fb_q;
					out_dg   <= dg_q;
					out_many <= rec_q.many;
				end
			end
			default: cnt_q <= '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/polygon_normal_newell_core.sv =====
`default_nettype none
// Unit normal of a polygon facet by Newell's method.
// s_* channel: one vertex per transaction, tdata = {pos_z, pos_y, pos_x},
// each signed Q12.12; tlast marks the last vertex of the facet.
// m_* channel: one transaction per facet, tdata = {normal_z, normal_y, normal_x}
// in signed Q1.14, tuser = {too_many, degenerate, used_fallback}.
// cfg_*: writes length_threshold; write only while the block is idle.
// Each vertex is registered and then added in the accumulator's edge step
// (difference, multiply-add); the last vertex also adds the closing edge
// and hands the facet on. The back end shares one 33x33 multiplier and
// runs the square test, optional edge cross product, normalizing shift (one
// bit a cycle), sum of squares, square root and three divides; a facet of
// fewer than three vertices goes straight to the output.
// A two-entry facet queue lets the accumulator keep taking vertices while
// the back end works.
// When the receiver stalls, the result holds in the output register and the
// back end waits to write the next one; the queue fills, then s_tready drops.
// Reset clears the facet state, the queue and the output valid, and loads
// the threshold with its default.
module polygon_normal_newell_core import pnn_pkg::*; #(
	parameter int MAX_VERTS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // pos_x, pos_y, pos_z
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // normal_x, normal_y, normal_z
	output logic [2:0]       m_tuser,   // used_fallback, degenerate, too_many
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic [THR_W-1:0] thr_q;
	xyz_t             pos;
	logic             push_valid, push_ready, pop_valid, pop_ready;
	facet_t           push_data, pop_data;
	logic [NRM_W-1:0] nx, ny, nz;
	logic             fb, dg, many;

	assign cfg_ready = 1'b1;
	assign pos.x = $signed(s_tdata[23:0]);
	assign pos.y = $signed(s_tdata[47:24]);
	assign pos.z = $signed(s_tdata[71:48]);
	assign m_tdata = {nz, ny, nx};
	assign m_tuser = {many, dg, fb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	pnn_front #(.MAX_VERTS(MAX_VERTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_pos     (pos),
		.in_last    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pnn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pnn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr       (thr_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_nx    (nx),
		.out_ny    (ny),
		.out_nz    (nz),
		.out_fb    (fb),
		.out_dg    (dg),
		.out_many  (many)
	);

endmodule
`default_nettype wire

// ===== rtl/pnn_checker.sv =====
`default_nettype none
module pnn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed under stall");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 48'd0)
		else $error("degenerate facet with nonzero normal");

	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata != 48'd0)
		else $error("valid facet with zero normal");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("vertex taken while closing a facet");

endmodule

bind polygon_normal_newell_core pnn_checker u_pnn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/polygon_normal_newell_core_tb.sv =====
`timescale 1ns / 1ps
module polygon_normal_newell_core_tb;
	import pnn_pkg::*;

	localparam int MAXV = 256;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic fallback, degen, many;
	} normal_t;

	class normal_scoreboard;
		logic [31:0] threshold;
		longint first_v[3], second_v[3], third_v[3], prev_v[3];
		longint newell[3];
		int count;
		normal_t pending_q[$];
		int errors;

		function new();
			threshold = THR_RESET;
			errors = 0;
			clear_facet();
		endfunction

		function void clear_facet();
			for (int i = 0; i < 3; i++) begin
				first_v[i] = 0; second_v[i] = 0; third_v[i] = 0; prev_v[i] = 0;
				newell[i] = 0;
			end
			count = 0;
		endfunction

		function void add_edge(longint a[3], longint b[3]);
			newell[0] += (a[1] - b[1]) * (a[2] + b[2]);
			newell[1] += (a[2] - b[2]) * (a[0] + b[0]);
			newell[2] += (a[0] - b[0]) * (a[1] + b[1]);
		endfunction

		function logic [63:0] magnitude(longint v);
			logic [63:0] u;
			u = v;
			return (v < 0) ? -u : u;
		endfunction

		function logic [63:0] root64(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function bit unit_vector(longint c[3], output logic signed [15:0] n[3]);
			logic [63:0] m[3], mx, q, len, v;
			int rs, ls;
			mx = 0; q = 0; rs = 0; ls = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = magnitude(c[i]);
				if (m[i] > mx) mx = m[i];
				n[i] = 0;
			end
			if (mx == 0) return 0;
			while ((mx >> rs) >= (64'd1 << 31)) rs++;
			while ((mx << ls) < (64'd1 << 30)) ls++;
			for (int i = 0; i < 3; i++) begin
				m[i] = (m[i] >> rs) << ls;
				q += m[i] * m[i];
			end
			len = root64(q);
			for (int i = 0; i < 3; i++) begin
				v = (m[i] * 64'd16384 + len / 2) / len;
				n[i] = (c[i] < 0) ? -v[15:0] : v[15:0];
			end
			return 1;
		endfunction

		function void note_vertex(crd_t px, crd_t py, crd_t pz, bit last);
			longint v[3], e1[3], e2[3], cr[3];
			logic signed [15:0] n[3];
			logic [129:0] sq, lim;
			normal_t r;
			int kept;
			v[0] = px; v[1] = py; v[2] = pz;
			if (count < MAXV) begin
				if (count == 0) first_v = v;
				else add_edge(prev_v, v);
				if (count == 1) second_v = v;
				if (count == 2) third_v = v;
				prev_v = v;
			end
			if (count <= MAXV) count++;
			if (!last) return;
			add_edge(prev_v, first_v);
			r.many = count > MAXV;
			kept = r.many ? MAXV : count;
			r.fallback = 0;
			r.degen = 0;
			for (int i = 0; i < 3; i++) n[i] = 0;
			if (kept < 3) begin
				r.degen = 1;
			end else begin
				sq = 130'(magnitude(newell[0])) * 130'(magnitude(newell[0]))
					+ 130'(magnitude(newell[1])) * 130'(magnitude(newell[1]))
					+ 130'(magnitude(newell[2])) * 130'(magnitude(newell[2]));
				lim = 130'(threshold) * 130'(threshold);
				if (sq > lim) begin
					void'(unit_vector(newell, n));
				end else begin
					for (int i = 0; i < 3; i++) begin
						e1[i] = second_v[i] - first_v[i];
						e2[i] = third_v[i] - first_v[i];
					end
					cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
					cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
					cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
					r.fallback = 1;
					if (!unit_vector(cr, n)) r.degen = 1;
				end
			end
			if (r.degen) for (int i = 0; i < 3; i++) n[i] = 0;
			r.nx = n[0]; r.ny = n[1]; r.nz = n[2];
			pending_q.insert(pending_q.size(), r);
			clear_facet();
		endfunction

		function void compare(string field, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$display("%0t: mismatch %s expected %0d actual %0d", $time, field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_normal(logic [47:0] data, logic [2:0] flags);
			normal_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h/%b", $time, data, flags);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			compare("normal_x", e.nx, $signed(data[15:0]));
			compare("normal_y", e.ny, $signed(data[31:16]));
			compare("normal_z", e.nz, $signed(data[47:32]));
			compare("used_fallback", e.fallback, flags[0]);
			compare("degenerate", e.degen, flags[1]);
			compare("too_many", e.many, flags[2]);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	normal_scoreboard sb = new();
	int cycles = 0;
	int items = 0;
	int results = 0;
	bit no_idle = 0;

	polygon_normal_newell_core #(.MAX_VERTS(MAXV)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_vertex(s_tdata[23:0], s_tdata[47:24], s_tdata[71:48], s_tlast);
			if (m_tvalid && m_tready) begin
				sb.check_normal(m_tdata, m_tuser);
				results++;
			end
		end
	end

	function automatic int gap_len(int zero_weight);
		int r;
		r = $urandom_range(0, 19);
		if (r < zero_weight) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	initial begin
		bit held;
		int g;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results >= 20) begin
				held = 1;
				m_tready = 0;
				repeat (3000) @(negedge clk);
			end
			g = no_idle ? 0 : gap_len(13);
			if (g > 0) begin
				m_tready = 0;
				repeat (g) @(negedge clk);
			end
			m_tready = 1;
		end
	end

	task automatic send_vertex(crd_t x, crd_t y, crd_t z, bit last);
		int g;
		g = no_idle ? 0 : gap_len(12);
		if (g > 0) begin
			s_tvalid = 0;
			repeat (g) @(negedge clk);
		end
		s_tdata = {z, y, x};
		s_tlast = last;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items++;
	endtask

	function automatic crd_t rand_crd(int span);
		if (span == 0) return crd_t'($urandom);
		return crd_t'($urandom_range(0, 2 * span) - span);
	endfunction

	// shape: 0 full range, 1 moderate, 2 collinear, 3 identical, 4 tiny
	task automatic send_facet(int n, int shape);
		crd_t b[3], d[3], p[3];
		for (int k = 0; k < 3; k++) begin
			b[k] = rand_crd(shape == 4 ? 3 : 100000);
			d[k] = rand_crd(shape == 4 ? 2 : 500);
		end
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++)
				case (shape)
					0: p[k] = rand_crd(0);
					1: p[k] = rand_crd(200000);
					2: p[k] = crd_t'(b[k] + i * d[k]);
					3: p[k] = b[k];
					default: p[k] = rand_crd(3);
				endcase
			send_vertex(p[0], p[1], p[2], i == n - 1);
		end
		s_tvalid = 0;
	endtask

	task automatic write_threshold(logic [31:0] value);
		wait (sb.pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_data = value;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sb.threshold = value;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_phase(int count);
		int target, r, n;
		target = items + count;
		send_facet(MAXV + 1, 1);
		while (items < target) begin
			no_idle = ($urandom_range(0, 7) == 0);
			r = $urandom_range(0, 99);
			if (r < 6) n = $urandom_range(1, 2);
			else if (r == 6) n = $urandom_range(MAXV, MAXV + 4);
			else n = $urandom_range(3, 9);
			send_facet(n, $urandom_range(0, 4));
		end
		no_idle = 0;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_vertex(24'sh7FFFFF, -24'sh800000, 0, 1);
		send_vertex(-24'sh800000, 24'sh7FFFFF, 1, 0);
		send_vertex(5, 6, 7, 1);
		send_vertex(0, 0, 0, 0);
		send_vertex(4096, 0, 0, 0);
		send_vertex(0, 4096, 0, 1);
		send_vertex(-24'sh800000, -24'sh800000, 24'sh7FFFFF, 0);
		send_vertex(24'sh7FFFFF, -24'sh800000, -24'sh800000, 0);
		send_vertex(-24'sh800000, 24'sh7FFFFF, -24'sh800000, 1);
		send_vertex(100, 200, 300, 0);
		send_vertex(100, 200, 300, 0);
		send_vertex(100, 200, 300, 1);
		send_vertex(0, 0, 0, 0);
		send_vertex(10, 20, 30, 0);
		send_vertex(20, 40, 60, 1);
		send_vertex(0, 0, 0, 0);
		send_vertex(1, 0, 0, 0);
		send_vertex(1, 1, 0, 0);
		send_vertex(0, 1, 0, 1);
		s_tvalid = 0;

		random_phase(300);
		write_threshold(32'd0);
		random_phase(300);
		write_threshold(32'hFFFFFFFF);
		random_phase(300);
		write_threshold($urandom_range(1, 32'h00FFFFFF));
		random_phase(300);
		write_threshold(THR_RESET);
		random_phase(300);

		wait (sb.pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/pnn_pkg.sv
rtl/pnn_front.sv
rtl/pnn_queue.sv
rtl/pnn_back.sv
rtl/polygon_normal_newell_core.sv
rtl/pnn_checker.sv
tb/sv/polygon_normal_newell_core_tb.sv
